>>> hdl/assert_macros.svh
// Assertion macros used by the port-level checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Property that must hold in the cycle after a trigger.
`define CHK_NEXT(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);
`endif

>>> hdl/sdcp_pkg.sv
// Shared types and constants of the serial drive command parser.
// No dependencies.
`default_nettype none
package sdcp_pkg;
  localparam int unsigned LineLimit = 64;
  localparam int unsigned LcW = $clog2(LineLimit);

  typedef enum logic [2:0] {
    EV_PING = 3'd0, EV_STOP = 3'd1, EV_MOTOR = 3'd2, EV_TIMEOUT = 3'd3, EV_HEART = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    REG_TIMEOUT = 2'd0, REG_HEART = 2'd1, REG_MAXSPD = 2'd2, REG_TRACK = 2'd3
  } reg_idx_t;

  localparam logic [3:0] PH_KW = 4'd0;
  localparam logic [3:0] PH_DONE = 4'd10;
  localparam logic [3:0] PH_DEAD = 4'd11;
  localparam logic [3:0] PH_KWHIT = 4'd12;

  typedef struct packed {
    logic start_div;
  } dp_cmd_t;

  typedef struct packed {
    logic       n_res;      // 0: one result, 1: two
    logic       any_res;
    logic       div_done;
  } dp_sts_t;

  function automatic logic [3:0] kw_hits(input logic [1:0] pos, input logic [7:0] c);
    logic [3:0] m;
    m = '0;
    unique case (pos)
      2'd0: begin m[0] = c == "P"; m[1] = c == "p"; m[2] = c == "S"; m[3] = c == "s"; end
      2'd1: begin m[0] = c == "I"; m[1] = c == "i"; m[2] = c == "T"; m[3] = c == "t"; end
      2'd2: begin m[0] = c == "N"; m[1] = c == "n"; m[2] = c == "O"; m[3] = c == "o"; end
      default: begin m[0] = c == "G"; m[1] = c == "g"; m[2] = c == "P"; m[3] = c == "p"; end
    endcase
    return m;
  endfunction
endpackage
`default_nettype wire

>>> hdl/serial_drive_command_parser.sv
// Top level of the serial drive command parser: controller plus datapath.
// Depends on sdcp_pkg, sdcp_ctrl and sdcp_dp.
//
// One item at a time: in_ready is high only while the block is idle. A byte or
// tick is parsed in its accept cycle; every item then passes through the scaling
// unit: wheel sum and difference are registered, then the multiply results, then 37
// steps of a bit-serial divider for the turn rate, and last turn rate and forward
// speed are registered (forward speed divided by 255 through a reciprocal multiply).
// The first result beat is offered after that; an item with no result then frees the
// input, and each result beat is held while out_ready is low. Up to two result
// beats per item; last marks the final one.
`default_nettype none
module serial_drive_command_parser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               kind,
  input  wire logic [7:0]         rx_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              event_res,
  output logic signed [19:0]      forward_speed_q8,
  output logic signed [23:0]      turn_rate_q16,
  output logic signed [15:0]      motor_echo,
  output logic signed [15:0]      direction_echo,
  output logic [7:0]              speed_echo,
  output logic                    last,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_idx,
  input  wire logic [15:0]        cfg_data
);
  sdcp_pkg::dp_cmd_t cmd;
  sdcp_pkg::dp_sts_t sts;
  logic out_sel;

  sdcp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_sel(out_sel), .last(last),
    .cmd(cmd), .sts(sts)
  );

  sdcp_dp u_dp (
    .clk(clk), .rst(rst), .accept(in_valid && in_ready), .kind(kind), .rx_byte(rx_byte),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data), .cmd(cmd), .sts(sts),
    .out_sel(out_sel), .event_res(event_res), .forward_speed_q8(forward_speed_q8),
    .turn_rate_q16(turn_rate_q16), .motor_echo(motor_echo),
    .direction_echo(direction_echo), .speed_echo(speed_echo)
  );
endmodule
`default_nettype wire

>>> hdl/sdcp_ctrl.sv
// Controller of the serial drive command parser: sequences byte, division and output.
// Depends on sdcp_pkg.
`default_nettype none
module sdcp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_sel,
  output logic                  last,
  output sdcp_pkg::dp_cmd_t     cmd,
  input  wire sdcp_pkg::dp_sts_t sts
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_DIV = 4'b0010, S_OUT0 = 4'b0100, S_OUT1 = 4'b1000
  } state_t;
  state_t state, state_next;

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    out_valid = 1'b0;
    out_sel = 1'b0;
    last = 1'b0;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_DIV;
          cmd.start_div = 1'b1;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          if (sts.any_res) state_next = S_OUT0;
          else state_next = S_IDLE;
        end
      end
      S_OUT0: begin
        out_valid = 1'b1;
        last = !sts.n_res;
        if (out_ready) state_next = sts.n_res ? S_OUT1 : S_IDLE;
      end
      S_OUT1: begin
        out_valid = 1'b1;
        out_sel = 1'b1;
        last = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule
`default_nettype wire

>>> hdl/sdcp_dp.sv
// Datapath of the serial drive command parser: line parser, wheels, timers, scaling.
// Depends on sdcp_pkg.
`default_nettype none
module sdcp_dp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire logic                 kind,
  input  wire logic [7:0]           rx_byte,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_idx,
  input  wire logic [15:0]          cfg_data,
  input  wire sdcp_pkg::dp_cmd_t    cmd,
  output sdcp_pkg::dp_sts_t         sts,
  input  wire logic                 out_sel,
  output logic [2:0]                event_res,
  output logic signed [19:0]        forward_speed_q8,
  output logic signed [23:0]        turn_rate_q16,
  output logic signed [15:0]        motor_echo,
  output logic signed [15:0]        direction_echo,
  output logic [7:0]                speed_echo
);
  localparam int unsigned NumW = 37;   // |(R-L)*max*65536| < 2^36
  localparam int unsigned DenW = 19;

  logic [15:0] cfg_timeout, cfg_heart;
  logic [10:0] cfg_maxspd, cfg_track;

  logic [3:0] phase, phase_next;
  logic [3:0] kwm, kwm_next;
  logic [sdcp_pkg::LcW-1:0] lcnt, lcnt_next;
  logic [16:0] acc, acc_next;
  logic neg, neg_next;
  logic signed [15:0] num1, num1_next, num2, num2_next;
  logic signed [8:0] lw, lw_next, rw, rw_next;
  logic [15:0] ms_cmd, ms_cmd_next, ms_hb, ms_hb_next;

  logic [2:0] ev0, ev0_next, ev1, ev1_next;
  logic any_res, any_next, two_res, two_next, motor_r, motor_next;
  logic [7:0] sp_r, sp_next;

  logic signed [19:0] fwd_r;
  logic signed [23:0] turn_r;
  logic [NumW-1:0] rem;
  logic [NumW-1:0] quo;
  logic [DenW-1:0] den;
  logic [5:0] dcnt;
  logic busy, q_neg, div_zero, sum_neg, diff_nz;
  logic [1:0] mstep;
  logic signed [9:0] sum_r, diff_r;
  logic signed [21:0] prod_s, prod_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_timeout <= 16'd200;
      cfg_heart <= 16'd100;
      cfg_maxspd <= 11'd500;
      cfg_track <= 11'd300;
    end else if (cfg_we) begin
      unique case (sdcp_pkg::reg_idx_t'(cfg_idx))
        sdcp_pkg::REG_TIMEOUT: cfg_timeout <= cfg_data;
        sdcp_pkg::REG_HEART: cfg_heart <= cfg_data;
        sdcp_pkg::REG_MAXSPD: cfg_maxspd <= cfg_data[10:0];
        sdcp_pkg::REG_TRACK: cfg_track <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  function automatic logic signed [15:0] nval(input logic n, input logic [16:0] a);
    if (n) return 16'(-$signed({1'b0, a}));
    return (a > 17'd32767) ? 16'sd32767 : 16'(a);
  endfunction

  logic [3:0] pc_phase, pc_kwm;
  logic [sdcp_pkg::LcW-1:0] pc_lcnt;
  logic [16:0] pc_acc;
  logic pc_neg;
  logic [3:0] dig;
  logic isdig, blank;
  logic [1:0] sub, idx;
  logic [3:0] hits;
  logic [20:0] acc10;
  logic kwline;
  logic signed [15:0] spv;
  logic signed [8:0] wv;
  logic [16:0] c1, c2;

  always_comb begin
    phase_next = phase; kwm_next = kwm; lcnt_next = lcnt; acc_next = acc;
    neg_next = neg; num1_next = num1; num2_next = num2; lw_next = lw; rw_next = rw;
    ms_cmd_next = ms_cmd; ms_hb_next = ms_hb;
    ev0_next = ev0; ev1_next = ev1; any_next = 1'b0; two_next = 1'b0;
    motor_next = 1'b0; sp_next = 8'd0;
    pc_phase = phase; pc_kwm = kwm; pc_lcnt = lcnt; pc_acc = acc; pc_neg = neg;
    dig = rx_byte[3:0];
    isdig = rx_byte >= "0" && rx_byte <= "9";
    blank = rx_byte == 8'd32 || rx_byte == 8'd9 || rx_byte == 8'd11 || rx_byte == 8'd12;
    sub = 2'd0; idx = 2'd0; hits = '0; acc10 = '0; kwline = 1'b0; spv = '0; wv = '0;
    c1 = 17'({1'b0, ms_cmd} + 17'd1); c2 = 17'({1'b0, ms_hb} + 17'd1);
    if (!kind) begin
      if (lcnt >= sdcp_pkg::LcW'(sdcp_pkg::LineLimit - 1)) begin
        pc_phase = sdcp_pkg::PH_KW; pc_kwm = 4'hF; pc_lcnt = '0; pc_acc = '0; pc_neg = 1'b0;
      end
      phase_next = pc_phase; kwm_next = pc_kwm; lcnt_next = pc_lcnt;
      acc_next = pc_acc; neg_next = pc_neg;
      if (rx_byte == 8'd10 || rx_byte == 8'd13) begin
        kwline = pc_phase == sdcp_pkg::PH_KWHIT ||
          (pc_phase == sdcp_pkg::PH_KW && pc_lcnt == sdcp_pkg::LcW'(4) && pc_kwm != 4'd0);
        if (kwline) begin
          any_next = 1'b1;
          if (pc_kwm[1:0] != 2'd0) ev0_next = sdcp_pkg::EV_PING;
          else begin
            ev0_next = sdcp_pkg::EV_STOP;
            lw_next = '0; rw_next = '0; ms_cmd_next = '0;
          end
        end else if (pc_phase == 4'd9 || pc_phase == sdcp_pkg::PH_DONE) begin
          spv = nval(pc_neg, pc_acc);
          if (spv < 0) spv = '0;
          if (spv > 16'sd255) spv = 16'sd255;
          wv = (num2 == 0) ? -9'(spv) : 9'(spv);
          if (num1 == 16'sd0) lw_next = wv;
          else if (num1 == 16'sd1) rw_next = wv;
          ms_cmd_next = '0;
          any_next = 1'b1; motor_next = 1'b1;
          ev0_next = sdcp_pkg::EV_MOTOR;
          sp_next = spv[7:0];
        end
        phase_next = sdcp_pkg::PH_KW; kwm_next = 4'hF; lcnt_next = '0;
        acc_next = '0; neg_next = 1'b0;
      end else begin
        lcnt_next = pc_lcnt + 1'b1;
        if (pc_phase == sdcp_pkg::PH_KW) begin
          if (rx_byte == 8'd0)
            phase_next = (pc_lcnt == sdcp_pkg::LcW'(4) && pc_kwm != 0) ?
              sdcp_pkg::PH_KWHIT : sdcp_pkg::PH_DEAD;
          else if (pc_lcnt == '0 && rx_byte == "<") phase_next = 4'd1;
          else if (pc_lcnt >= sdcp_pkg::LcW'(4)) phase_next = sdcp_pkg::PH_DEAD;
          else begin
            hits = sdcp_pkg::kw_hits(pc_lcnt[1:0], rx_byte);
            kwm_next = pc_kwm & hits;
            if ((pc_kwm & hits) == 4'd0) phase_next = sdcp_pkg::PH_DEAD;
          end
        end else if (pc_phase >= 4'd1 && pc_phase <= 4'd9) begin
          priority case (pc_phase)
            4'd1, 4'd4, 4'd7: sub = 2'd0;
            4'd2, 4'd5, 4'd8: sub = 2'd1;
            default: sub = 2'd2;
          endcase
          idx = (pc_phase <= 4'd3) ? 2'd0 : ((pc_phase <= 4'd6) ? 2'd1 : 2'd2);
          acc10 = 21'(pc_acc) * 21'd10 + 21'(dig);
          if (sub == 2'd0 && blank) begin
          end else if (sub == 2'd0 && (rx_byte == "+" || rx_byte == "-")) begin
            acc_next = '0; neg_next = rx_byte == "-"; phase_next = pc_phase + 1'b1;
          end else if (sub != 2'd2 && isdig) begin
            if (sub == 2'd0) neg_next = 1'b0;
            acc_next = 17'(dig);
            phase_next = 4'(3 + 3 * idx);
          end else if (sub == 2'd2 && isdig) begin
            acc_next = (acc10 > 21'd32768) ? 17'd32768 : acc10[16:0];
          end else if (sub == 2'd2 && idx == 2'd2) begin
            phase_next = sdcp_pkg::PH_DONE;
          end else if (sub == 2'd2 && rx_byte == ",") begin
            if (idx == 2'd0) num1_next = nval(pc_neg, pc_acc);
            else num2_next = nval(pc_neg, pc_acc);
            phase_next = 4'(1 + 3 * (idx + 1));
          end else phase_next = sdcp_pkg::PH_DEAD;
        end
      end
    end else begin
      if (ms_cmd != 16'hFFFF) ms_cmd_next = c1[15:0];
      if (ms_hb != 16'hFFFF) ms_hb_next = c2[15:0];
      if (ms_cmd_next > cfg_timeout && (lw != 0 || rw != 0)) begin
        lw_next = '0; rw_next = '0;
        any_next = 1'b1;
        ev0_next = sdcp_pkg::EV_TIMEOUT;
        if (ms_hb_next > cfg_heart) begin
          ms_hb_next = '0; two_next = 1'b1; ev1_next = sdcp_pkg::EV_HEART;
        end
      end else if (ms_hb_next > cfg_heart) begin
        ms_hb_next = '0; any_next = 1'b1; ev0_next = sdcp_pkg::EV_HEART;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= sdcp_pkg::PH_KW; kwm <= 4'hF; lcnt <= '0; acc <= '0; neg <= 1'b0;
      num1 <= '0; num2 <= '0; lw <= '0; rw <= '0; ms_cmd <= '0; ms_hb <= '0;
      any_res <= 1'b0; two_res <= 1'b0; motor_r <= 1'b0;
    end else if (accept) begin
      phase <= phase_next; kwm <= kwm_next; lcnt <= lcnt_next; acc <= acc_next;
      neg <= neg_next; num1 <= num1_next; num2 <= num2_next; lw <= lw_next;
      rw <= rw_next; ms_cmd <= ms_cmd_next; ms_hb <= ms_hb_next;
      any_res <= any_next; two_res <= two_next; motor_r <= motor_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ev0 <= ev0_next; ev1 <= ev1_next; sp_r <= sp_next;
    end
  end

  // scaling: multiply step, restoring division one bit a cycle for the turn rate,
  // reciprocal multiply for the forward speed
  assign prod_s = 22'(sum_r) * $signed({11'd0, cfg_maxspd});
  assign prod_d = 22'(diff_r) * $signed({11'd0, cfg_maxspd});

  localparam logic [27:0] Recip255 = 28'd134744073;   // ceil(2^35 / 255)

  logic [NumW-1:0] rem_sh;
  logic [NumW-1:0] trial;
  logic [21:0] mag;
  logic [NumW-1:0] qmag;
  logic signed [NumW:0] qsig;
  logic [29:0] fmag;
  logic [21:0] smag;
  logic [29:0] fnum;
  logic [57:0] fprod;
  assign rem_sh = {rem[NumW-2:0], quo[NumW-1]};
  assign trial = rem_sh - NumW'(den);
  assign mag = prod_d[21] ? 22'(-prod_d) : 22'(prod_d);
  assign smag = prod_s[21] ? 22'(-prod_s) : 22'(prod_s);
  assign fmag = 30'(smag) << 7;
  assign fprod = 58'(fnum) * 58'(Recip255);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; mstep <= '0; dcnt <= '0;
    end else if (cmd.start_div) begin
      busy <= 1'b1; mstep <= 2'd1;
    end else if (busy) begin
      if (mstep == 2'd1) mstep <= 2'd2;
      else if (mstep == 2'd2) begin
        mstep <= 2'd3; dcnt <= 6'(NumW);
      end else if (dcnt != '0) dcnt <= dcnt - 1'b1;
      else busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy && mstep == 2'd1) begin
      sum_r <= 10'(lw) + 10'(rw);
      diff_r <= 10'(rw) - 10'(lw);
    end else if (busy && mstep == 2'd2) begin
      den <= 19'(cfg_track) * 19'd255;
      div_zero <= cfg_track == '0;
      q_neg <= prod_d[21];
      diff_nz <= prod_d != '0;
      sum_neg <= prod_s[21];
      rem <= '0; quo <= NumW'(mag) << 16;
      fnum <= fmag;
    end else if (busy && dcnt != '0) begin
      if (rem_sh >= NumW'(den)) begin
        rem <= trial; quo <= {quo[NumW-2:0], 1'b1};
      end else begin
        rem <= rem_sh; quo <= {quo[NumW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    qmag = quo;
    if (div_zero) qsig = diff_nz ? (q_neg ? -(NumW+1)'(8388608) : (NumW+1)'(8388607)) : '0;
    else qsig = q_neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  end

  always_ff @(posedge clk) begin
    if (busy && mstep == 2'd3 && dcnt == '0) begin
      if (qsig > (NumW+1)'(8388607)) turn_r <= 24'sd8388607;
      else if (qsig < -(NumW+1)'(8388608)) turn_r <= -24'sd8388608;
      else turn_r <= qsig[23:0];
      fwd_r <= sum_neg ? -20'(fprod[57:35]) : 20'(fprod[57:35]);
    end
  end

  assign sts.div_done = busy && mstep == 2'd3 && dcnt == '0;
  assign sts.any_res = any_res;
  assign sts.n_res = two_res;

  always_comb begin
    event_res = out_sel ? ev1 : ev0;
    if (motor_r && !out_sel) begin
      forward_speed_q8 = fwd_r; turn_rate_q16 = turn_r;
      motor_echo = num1; direction_echo = num2; speed_echo = sp_r;
    end else begin
      forward_speed_q8 = '0; turn_rate_q16 = '0;
      motor_echo = '0; direction_echo = '0; speed_echo = '0;
    end
  end
endmodule
`default_nettype wire

>>> hdl/sdcp_checker.sv
// Port-level checker for the serial drive command parser, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module sdcp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] event_res,
  input wire logic       last
);
  `CHK_IMPLY(a_no_overlap, clk, rst, !(in_ready && out_valid), "input taken during output")
  `CHK_IMPLY(a_ev_range, clk, rst, !out_valid || event_res <= 3'd4, "bad event code")
  `CHK_NEXT(a_busy_after, clk, rst, in_valid && in_ready, !in_ready, "second item taken")
  `CHK_NEXT(a_last_idle, clk, rst, out_valid && out_ready && last, !out_valid, "beat after last")
endmodule
bind serial_drive_command_parser sdcp_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .event_res(event_res), .last(last)
);
`default_nettype wire

>>> sim/sdcp_checker.sv
// Checker for the serial drive command parser: tracks parser state from accepted beats,
// predicts the event beats and compares them with the output channel.
// Depends on sdcp_pkg.
`default_nettype none
module sdcp_tb_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic               kind,
  input  wire logic [7:0]         rx_byte,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic [2:0]         event_res,
  input  wire logic signed [19:0] forward_speed_q8,
  input  wire logic signed [23:0] turn_rate_q16,
  input  wire logic signed [15:0] motor_echo,
  input  wire logic signed [15:0] direction_echo,
  input  wire logic [7:0]         speed_echo,
  input  wire logic               last,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_idx,
  input  wire logic [15:0]        cfg_data,
  output int                      errors,
  output int                      pending
);

  typedef struct packed {
    logic [2:0]         ev;
    logic signed [19:0] fwd;
    logic signed [23:0] turn;
    logic signed [15:0] motor;
    logic signed [15:0] dir;
    logic [7:0]         spd;
    logic               fin;
  } drive_event_t;

  drive_event_t events_due[$];

  int unsigned timeout_ms, heart_ms, max_spd, track;
  logic [3:0]  phase;
  logic [3:0]  kw_live;
  int          line_len;
  int unsigned accum;
  logic        negative;
  int          num_a, num_b;
  int          left_spd, right_spd;
  int unsigned cmd_age, heart_age;
  drive_event_t burst[2];
  int          n_burst;

  function automatic logic [7:0] keyword_char(int k, int p);
    string s;
    case (k)
      0: s = "PING";
      1: s = "ping";
      2: s = "STOP";
      default: s = "stop";
    endcase
    return s[p];
  endfunction

  function automatic int parsed_value(logic neg, int unsigned acc);
    if (neg) return -int'(acc);
    return (acc > 32767) ? 32767 : int'(acc);
  endfunction

  function automatic logic signed [19:0] forward_of(int l, int r, int unsigned mls);
    longint v;
    v = longint'(l + r) * longint'(mls) * 128;
    return 20'(v / 255);
  endfunction

  function automatic logic signed [23:0] turn_of(int l, int r, int unsigned mls,
                                                 int unsigned tw);
    longint num, v;
    num = longint'(r - l) * longint'(mls) * 65536;
    if (tw == 0) v = (num > 0) ? 8388607 : ((num < 0) ? -8388608 : 0);
    else v = num / (longint'(255) * longint'(tw));
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return 24'(v);
  endfunction

  task automatic add_event(logic [2:0] ev, logic signed [19:0] f, logic signed [23:0] t,
                           int m, int d, int s);
    drive_event_t e;
    e.ev = ev; e.fwd = f; e.turn = t;
    e.motor = 16'(m); e.dir = 16'(d); e.spd = 8'(s); e.fin = 1'b0;
    burst[n_burst] = e;
    n_burst++;
  endtask

  task automatic restart_line();
    phase = sdcp_pkg::PH_KW;
    kw_live = 4'hF;
    line_len = 0;
    accum = 0;
    negative = 1'b0;
  endtask

  task automatic parse_char(logic [7:0] c);
    logic isdig;
    logic [3:0] m;
    int idx, sub;
    isdig = (c >= "0") && (c <= "9");
    if (phase == sdcp_pkg::PH_KW) begin
      if (c == 8'd0) begin
        phase = (line_len == 4 && kw_live != 0) ? sdcp_pkg::PH_KWHIT : sdcp_pkg::PH_DEAD;
      end else if (line_len == 0 && c == "<") begin
        phase = 4'd1;
      end else if (line_len >= 4) begin
        phase = sdcp_pkg::PH_DEAD;
      end else begin
        m = '0;
        for (int k = 0; k < 4; k++) if (keyword_char(k, line_len) == c) m[k] = 1'b1;
        kw_live &= m;
        if (kw_live == 0) phase = sdcp_pkg::PH_DEAD;
      end
    end else if (phase >= 1 && phase <= 9) begin
      idx = (int'(phase) - 1) / 3;
      sub = (int'(phase) - 1) % 3;
      if (sub == 0 && (c == " " || c == 8'd9 || c == 8'd11 || c == 8'd12)) begin
      end else if (sub == 0 && (c == "+" || c == "-")) begin
        accum = 0;
        negative = (c == "-");
        phase = phase + 4'd1;
      end else if (sub < 2 && isdig) begin
        if (sub == 0) negative = 1'b0;
        accum = c - "0";
        phase = 4'(3 + 3 * idx);
      end else if (sub == 2 && isdig) begin
        accum = accum * 10 + (c - "0");
        if (accum > 32768) accum = 32768;
      end else if (sub == 2 && idx == 2) begin
        phase = sdcp_pkg::PH_DONE;
      end else if (sub == 2 && c == ",") begin
        if (idx == 0) num_a = parsed_value(negative, accum);
        else num_b = parsed_value(negative, accum);
        phase = 4'(1 + 3 * (idx + 1));
      end else begin
        phase = sdcp_pkg::PH_DEAD;
      end
    end
  endtask

  task automatic close_line();
    logic kw;
    int sp, w;
    kw = (phase == sdcp_pkg::PH_KWHIT) ||
         (phase == sdcp_pkg::PH_KW && line_len == 4 && kw_live != 0);
    if (kw) begin
      if (kw_live[1:0] != 0) begin
        add_event(sdcp_pkg::EV_PING, 0, 0, 0, 0, 0);
      end else begin
        left_spd = 0;
        right_spd = 0;
        cmd_age = 0;
        add_event(sdcp_pkg::EV_STOP, 0, 0, 0, 0, 0);
      end
    end else if (phase == 4'd9 || phase == sdcp_pkg::PH_DONE) begin
      sp = parsed_value(negative, accum);
      if (sp < 0) sp = 0;
      if (sp > 255) sp = 255;
      w = (num_b == 0) ? -sp : sp;
      if (num_a == 0) left_spd = w;
      else if (num_a == 1) right_spd = w;
      cmd_age = 0;
      add_event(sdcp_pkg::EV_MOTOR, forward_of(left_spd, right_spd, max_spd),
                turn_of(left_spd, right_spd, max_spd, track), num_a, num_b, sp);
    end
    restart_line();
  endtask

  task automatic track_beat(logic k, logic [7:0] c);
    n_burst = 0;
    if (!k) begin
      if (line_len >= int'(sdcp_pkg::LineLimit) - 1) restart_line();
      if (c == 8'd10 || c == 8'd13) close_line();
      else begin
        parse_char(c);
        line_len++;
      end
    end else begin
      if (cmd_age < 65535) cmd_age++;
      if (heart_age < 65535) heart_age++;
      if (cmd_age > timeout_ms && (left_spd != 0 || right_spd != 0)) begin
        left_spd = 0;
        right_spd = 0;
        add_event(sdcp_pkg::EV_TIMEOUT, 0, 0, 0, 0, 0);
      end
      if (heart_age > heart_ms) begin
        heart_age = 0;
        add_event(sdcp_pkg::EV_HEART, 0, 0, 0, 0, 0);
      end
    end
    if (n_burst > 0) burst[n_burst - 1].fin = 1'b1;
    for (int i = 0; i < n_burst; i++) events_due.push_back(burst[i]);
  endtask

  task automatic check_beat();
    drive_event_t e, got;
    got.ev = event_res; got.fwd = forward_speed_q8; got.turn = turn_rate_q16;
    got.motor = motor_echo; got.dir = direction_echo; got.spd = speed_echo; got.fin = last;
    if (events_due.size() == 0) begin
      errors++;
      $display("%0t: unexpected beat ev=%0d fwd=%0d turn=%0d m=%0d d=%0d s=%0d last=%0b",
               $time, got.ev, got.fwd, got.turn, got.motor, got.dir, got.spd, got.fin);
    end else begin
      e = events_due.pop_front();
      if (e != got) begin
        errors++;
        $display("%0t: mismatch expected ev=%0d fwd=%0d turn=%0d m=%0d d=%0d s=%0d last=%0b",
                 $time, e.ev, e.fwd, e.turn, e.motor, e.dir, e.spd, e.fin);
        $display("%0t:          actual ev=%0d fwd=%0d turn=%0d m=%0d d=%0d s=%0d last=%0b",
                 $time, got.ev, got.fwd, got.turn, got.motor, got.dir, got.spd, got.fin);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      errors = 0;
      timeout_ms = 200;
      heart_ms = 100;
      max_spd = 500;
      track = 300;
      restart_line();
      num_a = 0;
      num_b = 0;
      left_spd = 0;
      right_spd = 0;
      cmd_age = 0;
      heart_age = 0;
      events_due.delete();
    end else begin
      if (out_valid && out_ready) check_beat();
      if (cfg_we) begin
        case (sdcp_pkg::reg_idx_t'(cfg_idx))
          sdcp_pkg::REG_TIMEOUT: timeout_ms = cfg_data;
          sdcp_pkg::REG_HEART:   heart_ms = cfg_data;
          sdcp_pkg::REG_MAXSPD:  max_spd = cfg_data[10:0];
          sdcp_pkg::REG_TRACK:   track = cfg_data[10:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) track_beat(kind, rx_byte);
    end
    pending = events_due.size();
  end

endmodule
`default_nettype wire

>>> sim/tb_serial_drive_command_parser.sv
// Testbench top for the serial drive command parser: drives text lines and ticks,
// writes the registers between phases, and reports the verdict from sdcp_tb_checker.
// Depends on sdcp_pkg, sdcp_tb_checker and serial_drive_command_parser.
`default_nettype none
module tb_serial_drive_command_parser;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic kind = 1'b0;
  logic [7:0] rx_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] event_res;
  logic signed [19:0] forward_speed_q8;
  logic signed [23:0] turn_rate_q16;
  logic signed [15:0] motor_echo, direction_echo;
  logic [7:0] speed_echo;
  logic last;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [15:0] cfg_data = '0;
  int errors, pending;
  bit gaps_on = 1'b1;
  int sent = 0;
  int stall_left = 0;

  serial_drive_command_parser dut (.*);

  sdcp_tb_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    if (!gaps_on || rst) out_ready <= 1'b1;
    else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 10);
    end else out_ready <= 1'b1;
  end

  task automatic send_beat(logic k, logic [7:0] c);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    rx_byte <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_beat(1'b0, s[i]);
  endtask

  task automatic send_eol();
    send_beat(1'b0, $urandom_range(0, 1) ? 8'd13 : 8'd10);
  endtask

  task automatic send_ticks(int n);
    for (int i = 0; i < n; i++) send_beat(1'b1, 8'($urandom));
  endtask

  task automatic send_number(int v, bit huge);
    string s;
    int r;
    if ($urandom_range(0, 3) == 0)
      send_beat(1'b0, $urandom_range(0, 1) ? 8'd32 : 8'($urandom_range(9, 12)));
    if (v < 0) send_text("-");
    else if ($urandom_range(0, 5) == 0) send_text("+");
    if (huge) begin
      r = $urandom_range(5, 9);
      for (int i = 0; i < r; i++) send_beat(1'b0, 8'("0" + $urandom_range(0, 9)));
    end else begin
      s.itoa(v < 0 ? -v : v);
      send_text(s);
    end
  endtask

  task automatic send_motor(int id, int dir, int spd, bit huge);
    send_text("<");
    send_number(id, 1'b0);
    send_text(",");
    send_number(dir, 1'b0);
    send_text(",");
    send_number(spd, huge);
    if ($urandom_range(0, 3) != 0) send_text(">");
    send_eol();
  endtask

  task automatic send_random_line();
    int pick;
    string kw[4] = '{"PING", "ping", "STOP", "stop"};
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      send_motor($urandom_range(0, 9) == 0 ? $urandom_range(0, 40000) - 20000
                                           : $urandom_range(0, 1),
                 $urandom_range(0, 2) == 0 ? $urandom_range(0, 70000) - 35000
                                           : $urandom_range(0, 1),
                 $urandom_range(0, 320) - 30, $urandom_range(0, 9) == 0);
    end else if (pick < 55) begin
      send_text(kw[$urandom_range(0, 3)]);
      if ($urandom_range(0, 4) == 0) send_beat(1'b0, 8'($urandom));
      send_eol();
    end else if (pick < 75) begin
      send_ticks($urandom_range(1, 25));
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 8)) send_beat(1'b0, 8'($urandom));
      if ($urandom_range(0, 1)) send_eol();
    end else if (pick < 90) begin
      send_text("<1,0");
      send_beat(1'b0, 8'($urandom_range(0, 255)));
      send_text("9,12");
      send_eol();
    end else if (pick < 94) begin
      send_text("ST");
      send_beat(1'b0, 8'd0);
      send_text("OP");
      send_eol();
      send_text(kw[$urandom_range(0, 3)]);
      send_beat(1'b0, 8'd0);
      send_text("zz");
      send_eol();
    end else begin
      repeat ($urandom_range(60, 70)) send_beat(1'b0, 8'($urandom_range(33, 126)));
      send_eol();
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(sdcp_pkg::reg_idx_t idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_config(logic [15:0] t, logic [15:0] h, logic [15:0] m, logic [15:0] w);
    drain();
    write_reg(sdcp_pkg::REG_TIMEOUT, t);
    write_reg(sdcp_pkg::REG_HEART, h);
    write_reg(sdcp_pkg::REG_MAXSPD, m);
    write_reg(sdcp_pkg::REG_TRACK, w);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int n);
    int stop_at;
    stop_at = sent + n;
    while (sent < stop_at) send_random_line();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_text("PING"); send_eol();
    send_text("stop"); send_eol();
    send_motor(0, 1, 255, 1'b0);
    send_motor(1, 0, 255, 1'b0);
    send_text("<0,-5,"); send_text("99999"); send_eol();
    send_text("<7,-40000,12>"); send_eol();
    send_text("PING"); send_beat(1'b0, 8'd0); send_text("x"); send_eol();
    repeat (64) send_beat(1'b0, "a");
    send_eol();
    send_ticks(5);

    set_config(16'd3, 16'd2, 16'd2000, 16'd50);
    send_motor(0, 1, 255, 1'b0);
    send_motor(1, 0, 255, 1'b0);
    send_ticks(6);
    random_phase(260);

    set_config(16'd65535, 16'd65535, 16'd1, 16'd2000);
    random_phase(200);

    set_config(16'd1, 16'd1, 16'd2047, 16'd0);
    random_phase(220);

    set_config(16'd20, 16'd15, 16'd500, 16'd300);
    random_phase(300);

    set_config(16'd10, 16'd7, 16'd1234, 16'd777);
    gaps_on = 1'b0;
    random_phase(300);

    drain();
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
